@@ hdl/b64d_pkg.sv @@
// Shared types, codes and character classification for the base64 stream decoder.
// No dependencies; every other file of the block imports this package.
package b64d_pkg;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic [1:0] status;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    CLS_DATA = 2'd0,
    CLS_PAD  = 2'd1,
    CLS_BAD  = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_PAD  = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_t;

  typedef struct packed {
    cls_t       cls;
    logic [5:0] val;
  } sym_t;

  // Work for the back end: the results caused by one accepted item
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  n_bytes;
    logic        has_status;
    status_t     status;
  } job_t;

  localparam logic [7:0] CharPad = 8'h3d;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d) ||
           (c == 8'h0c) || (c == 8'h0b);
  endfunction

  function automatic sym_t classify(input logic [7:0] c);
    sym_t s;
    s.cls = CLS_BAD;
    s.val = 6'd0;
    priority if (c >= 8'h41 && c <= 8'h5a) begin
      s.cls = CLS_DATA;
      s.val = 6'(c - 8'd65);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s.cls = CLS_DATA;
      s.val = 6'(c - 8'd71);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.cls = CLS_DATA;
      s.val = 6'(c + 8'd4);
    end else if (c == 8'h2b) begin
      s.cls = CLS_DATA;
      s.val = 6'd62;
    end else if (c == 8'h2f) begin
      s.cls = CLS_DATA;
      s.val = 6'd63;
    end else if (c == CharPad) begin
      s.cls = CLS_PAD;
    end else begin
      s.cls = CLS_BAD;
    end
    return s;
  endfunction

endpackage

@@ hdl/b64d_front.sv @@
// Front end: accepts characters, collects groups of four, checks them and
// pushes one job per item that causes results. Uses b64d_pkg.
module b64d_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  b64d_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output b64d_pkg::job_t     q_job
);
  import b64d_pkg::*;

  logic [5:0] sext_r [3];
  cls_t       cls_r  [3];
  logic [1:0] gpos_r;
  status_t    sticky_r;

  logic [5:0] sext_nxt [3];
  cls_t       cls_nxt  [3];
  logic [1:0] gpos_nxt;
  status_t    sticky_nxt;

  sym_t    sym;
  status_t err;
  logic    accept;
  job_t    job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign sym      = classify(in_data.text_char);

  always_comb begin
    sext_nxt   = sext_r;
    cls_nxt    = cls_r;
    gpos_nxt   = gpos_r;
    sticky_nxt = sticky_r;
    err        = ST_OK;
    job.word       = {sext_r[0], sext_r[1], sext_r[2], sym.val};
    job.n_bytes    = 2'd0;
    job.has_status = 1'b0;
    job.status     = ST_OK;
    if (!is_blank(in_data.text_char)) begin
      if (gpos_r != 2'd3) begin
        sext_nxt[gpos_r] = sym.val;
        cls_nxt[gpos_r]  = sym.cls;
        gpos_nxt         = gpos_r + 2'd1;
      end else begin
        gpos_nxt = 2'd0;
        priority if (cls_r[0] != CLS_DATA || cls_r[1] != CLS_DATA) begin
          err = ST_BAD_CHAR;
        end else if (cls_r[2] == CLS_PAD && sym.cls != CLS_PAD) begin
          err = ST_BAD_PAD;
        end else if (cls_r[2] == CLS_BAD || sym.cls == CLS_BAD) begin
          err = ST_BAD_CHAR;
        end else begin
          err = ST_OK;
        end
        if (sticky_r == ST_OK) begin
          if (err != ST_OK) begin
            sticky_nxt = err;
          end else if (cls_r[2] == CLS_PAD) begin
            job.n_bytes = 2'd1;
          end else if (sym.cls == CLS_PAD) begin
            job.n_bytes = 2'd2;
          end else begin
            job.n_bytes = 2'd3;
          end
        end
      end
    end
    if (in_data.end_of_text) begin
      job.has_status = 1'b1;
      job.status     = (gpos_nxt != 2'd0) ? ST_BAD_LEN : sticky_nxt;
      // start a fresh text after the end mark
      for (int i = 0; i < 3; i++) begin
        sext_nxt[i] = 6'd0;
        cls_nxt[i]  = CLS_DATA;
      end
      gpos_nxt   = 2'd0;
      sticky_nxt = ST_OK;
    end
  end

  assign q_push = accept && (job.has_status || job.n_bytes != 2'd0);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        sext_r[i] <= 6'd0;
        cls_r[i]  <= CLS_DATA;
      end
      gpos_r   <= 2'd0;
      sticky_r <= ST_OK;
    end else if (accept) begin
      sext_r   <= sext_nxt;
      cls_r    <= cls_nxt;
      gpos_r   <= gpos_nxt;
      sticky_r <= sticky_nxt;
    end
  end

endmodule

@@ hdl/b64d_job_fifo.sv @@
// Short job queue between front and back ends of the decoder.
// Uses b64d_pkg for the job type.
module b64d_job_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64d_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output b64d_pkg::job_t head_job
);
  import b64d_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  job_t            slot_r [DEPTH];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full       = (cnt_r == FullCnt);
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == LastPtr) ? '0 : wr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == LastPtr) ? '0 : rd_r + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CntW'(1);
        2'b01:   cnt_r <= cnt_r - CntW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ hdl/b64d_back.sv @@
// Back end: walks each queued job and delivers its results one item a cycle
// while out_ready allows, through a registered output stage. Uses b64d_pkg.
module b64d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  b64d_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::out_item_t out_data
);
  import b64d_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r, item;
  logic [2:0] total;
  logic       last, load;

  assign total = {1'b0, head_job.n_bytes} + {2'b00, head_job.has_status};
  assign last  = ({1'b0, idx_r} + 3'd1 == total);
  assign load  = head_valid && (!out_valid_r || out_ready);
  assign pop   = load && last;
  assign idx_nxt = last ? 2'd0 : idx_r + 2'd1;

  always_comb begin
    item.last_of_run = last;
    if (idx_r < head_job.n_bytes) begin
      item.is_status = 1'b0;
      item.status    = ST_OK;
      unique case (idx_r)
        2'd0:    item.out_byte = head_job.word[23:16];
        2'd1:    item.out_byte = head_job.word[15:8];
        default: item.out_byte = head_job.word[7:0];
      endcase
    end else begin
      item.out_byte  = 8'd0;
      item.is_status = 1'b1;
      item.status    = head_job.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      idx_r       <= idx_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/base64_stream_decoder.sv @@
// Base64 stream decoder: one text character per input item, one decoded byte
// or the final status per result item.
//
// Input channel (in_valid/in_ready/in_data): a character and an end mark.
// Whitespace is skipped; other characters form groups of four. A good group
// yields one to three data bytes, stopped after the first error.
// The item with the end mark also yields a status item (ok, invalid
// character, invalid padding, invalid length) and starts a fresh text.
// Discard the bytes of a text whose status is not ok.
// Result channel (out_valid/out_ready/out_data): last_of_run marks the last
// result caused by one input item.
//
// Throughput: one character per cycle while the job queue (QUEUE_DEPTH
// entries) has room. The result stage delivers one result per cycle while
// out_ready is high, so an item that completes a group and carries the end
// mark holds it for four results. Results pass the job queue, then the
// result register. While out_ready is low the result register holds and the
// queue fills; in_ready drops when the queue is full.
// Reset clears the group state, empties the queue and drops out_valid.
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::out_item_t out_data
);
  import b64d_pkg::*;

  logic q_full, q_push, q_pop, q_head_valid;
  job_t q_job, q_head;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  b64d_job_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

@@ hdl/b64d_checker.sv @@
// Port-level checks on the result channel of the base64 stream decoder,
// bound to the top level. Uses b64d_pkg.
module b64d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input b64d_pkg::out_item_t out_data
);
  import b64d_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_status |-> out_data.last_of_run && out_data.out_byte == 8'd0)
    else $error("status item not last or carries a byte");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_status |-> out_data.status == ST_OK)
    else $error("data item carries a status code");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ bench/base64_stream_decoder_tb.sv @@
// Testbench for base64_stream_decoder: directed texts, then random texts over four
// handshake pressure phases, with every result checked against a decoder model.
// Depends on b64d_pkg and the base64_stream_decoder module.
module base64_stream_decoder_tb;
  import b64d_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomChars = 290;

  // Decoder model and the queue of results it predicts
  class b64_scoreboard;
    out_item_t   expected_q[$];
    logic [5:0]  sextet_hold[3];
    cls_t        class_hold[3];
    logic [1:0]  slot;
    status_t     first_error;
    int          errors;

    function new();
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      for (int i = 0; i < 3; i++) begin
        sextet_hold[i] = 6'd0;
        class_hold[i]  = CLS_DATA;
      end
      slot        = 2'd0;
      first_error = ST_OK;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d ||
             c == 8'h0c || c == 8'h0b;
    endfunction

    function cls_t sort_char(logic [7:0] c, output logic [5:0] v);
      v = 6'd0;
      if (c >= 8'h41 && c <= 8'h5a) begin
        v = 6'(c - 8'h41);
        return CLS_DATA;
      end
      if (c >= 8'h61 && c <= 8'h7a) begin
        v = 6'(c - 8'h61 + 8'd26);
        return CLS_DATA;
      end
      if (c >= 8'h30 && c <= 8'h39) begin
        v = 6'(c - 8'h30 + 8'd52);
        return CLS_DATA;
      end
      if (c == 8'h2b) begin
        v = 6'd62;
        return CLS_DATA;
      end
      if (c == 8'h2f) begin
        v = 6'd63;
        return CLS_DATA;
      end
      if (c == 8'h3d) return CLS_PAD;
      return CLS_BAD;
    endfunction

    function void note_input(in_item_t it);
      out_item_t   run_items[4];
      int          n;
      logic [5:0]  v;
      cls_t        cl;
      status_t     fault;
      logic [23:0] word;
      n = 0;
      if (!is_space(it.text_char)) begin
        cl = sort_char(it.text_char, v);
        if (slot != 2'd3) begin
          sextet_hold[slot] = v;
          class_hold[slot]  = cl;
          slot = slot + 2'd1;
        end else begin
          slot  = 2'd0;
          fault = ST_OK;
          if (class_hold[0] != CLS_DATA || class_hold[1] != CLS_DATA)
            fault = ST_BAD_CHAR;
          else if (class_hold[2] == CLS_PAD && cl != CLS_PAD)
            fault = ST_BAD_PAD;
          else if (class_hold[2] == CLS_BAD || cl == CLS_BAD)
            fault = ST_BAD_CHAR;
          if (first_error == ST_OK) begin
            if (fault != ST_OK) begin
              first_error = fault;
            end else begin
              word = {sextet_hold[0], sextet_hold[1], sextet_hold[2], v};
              run_items[n] = '{out_byte: word[23:16], is_status: 1'b0,
                               status: ST_OK, last_of_run: 1'b0};
              n++;
              if (class_hold[2] != CLS_PAD) begin
                run_items[n] = '{out_byte: word[15:8], is_status: 1'b0,
                                 status: ST_OK, last_of_run: 1'b0};
                n++;
              end
              if (cl != CLS_PAD) begin
                run_items[n] = '{out_byte: word[7:0], is_status: 1'b0,
                                 status: ST_OK, last_of_run: 1'b0};
                n++;
              end
            end
          end
        end
      end
      if (it.end_of_text) begin
        // a partial group outranks any earlier group error
        run_items[n] = '{out_byte: 8'h00, is_status: 1'b1,
                         status: (slot != 2'd0) ? ST_BAD_LEN : first_error,
                         last_of_run: 1'b0};
        n++;
        clear_text();
      end
      if (n > 0) run_items[n - 1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_q = {expected_q, run_items[i]};
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result with none expected: out_byte %0h is_status %0b status %0d",
               got.out_byte, got.is_status, got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("is_status", 8'(want.is_status), 8'(got.is_status));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  b64_scoreboard sb;
  logic [7:0]    chars_q[$];
  string         b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  int            sender_idle = 0;
  int            recv_stall = 0;
  int            sent_chars = 0;
  int            cycles = 0;

  base64_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(0, 99) < sender_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{text_char: c, end_of_text: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_chars++;
  endtask

  task automatic send_text();
    for (int i = 0; i < chars_q.size(); i++)
      send_char(chars_q[i], i == chars_q.size() - 1);
  endtask

  function automatic void append_char(logic [7:0] c);
    chars_q = {chars_q, c};
  endfunction

  task automatic load(string s);
    chars_q.delete();
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0a;
      3: return 8'h0d;
      4: return 8'h0c;
      default: return 8'h0b;
    endcase
  endfunction

  function automatic void push_char(logic [7:0] c);
    if ($urandom_range(0, 7) == 0) append_char(rand_blank());
    append_char(c);
  endfunction

  // Mostly well-formed texts with random content; the rest corrupted or noise
  function automatic void make_text();
    int n_groups;
    int kind;
    int pads;
    int pos;
    chars_q.delete();
    n_groups = $urandom_range(0, 4);
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 8)) push_char(8'($urandom_range(0, 255)));
    end else begin
      for (int g = 0; g < n_groups; g++) begin
        pads = 0;
        if (g == n_groups - 1 || $urandom_range(0, 15) == 0) pads = $urandom_range(0, 2);
        for (int s = 0; s < 4; s++)
          push_char(s >= 4 - pads ? 8'h3d : b64_chars[$urandom_range(0, 63)]);
      end
      if (kind == 7 && chars_q.size() > 0) begin
        pos = $urandom_range(0, chars_q.size() - 1);
        chars_q[pos] = $urandom_range(0, 1) ? 8'h3d : 8'($urandom_range(0, 255));
      end
      if (kind == 8) begin
        if (chars_q.size() > 0 && $urandom_range(0, 1))
          chars_q.delete($urandom_range(0, chars_q.size() - 1));
        else
          chars_q.insert($urandom_range(0, chars_q.size()), b64_chars[$urandom_range(0, 63)]);
      end
    end
    // carry the end mark on trailing whitespace now and then
    if (chars_q.size() == 0 || $urandom_range(0, 7) == 0) append_char(rand_blank());
  endfunction

  initial begin
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 75, 0, 27};
    stall_set = '{0, 0, 75, 27};
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // padded group mid-text, then a full group closing the text
    load("QQ==/+9z");
    send_text();
    chars_q = {8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d, 8'h0a};
    send_text();
    load("AA=A");
    send_text();
    chars_q = {8'h41, 8'h41, 8'h41, 8'hff};
    send_text();
    // group error, then a stray character: length wins
    chars_q = {8'h41, 8'h3d, 8'h41, 8'h00, 8'h41};
    send_text();
    drain();

    sent_chars = 0;
    for (int p = 0; p < 4; p++) begin
      sender_idle = idle_set[p];
      recv_stall  = stall_set[p];
      while (sent_chars < RandomChars * (p + 1) / 4) begin
        make_text();
        send_text();
      end
      // hold off the sender until the decoder has delivered everything
      drain();
    end

    recv_stall = 0;
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_job_fifo.sv
hdl/b64d_back.sv
hdl/base64_stream_decoder.sv
hdl/b64d_checker.sv
bench/base64_stream_decoder_tb.sv
